[hw/rtl/fdtp_pkg.sv]
// ----------------------------------------------------------------------------
// fdtp_pkg
// Types and constants shared by the file-system table parser modules.
// ----------------------------------------------------------------------------
package fdtp_pkg;

    localparam int IDX_W  = 19;
    localparam int TB_W   = 23;
    localparam int ERR_W  = 3;
    localparam int NAME_W = 24;
    localparam int WORD_W = 32;

    localparam logic [IDX_W-1:0] IDX_MAX     = {IDX_W{1'b1}};
    localparam logic [TB_W-1:0]  ENTRY_BYTES = TB_W'(12);
    localparam logic [TB_W-1:0]  TB_RESET    = TB_W'(4194304);

    typedef logic [ERR_W-1:0] t_err;

    localparam t_err ERR_NONE      = 3'd0;
    localparam t_err ERR_ROOT      = 3'd1;
    localparam t_err ERR_COUNT     = 3'd2;
    localparam t_err ERR_NO_STR    = 3'd3;
    localparam t_err ERR_NAME      = 3'd4;
    localparam t_err ERR_OUTSIDE   = 3'd5;
    localparam t_err ERR_DIR_BOUND = 3'd6;
    localparam t_err ERR_OVERFLOW  = 3'd7;

    // One table entry as it arrives.
    typedef struct packed {
        logic              start;
        logic [7:0]        kind;
        logic [NAME_W-1:0] name;
        logic [WORD_W-1:0] w2;
        logic [WORD_W-1:0] w3;
    } t_entry;

    // One open directory on the stack.
    typedef struct packed {
        logic [IDX_W-1:0] dir_idx;
        logic [IDX_W-1:0] end_idx;
    } t_stack_ent;

    // Parser state that the entry checks look at.
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] total;
        logic [TB_W-1:0]  table_bytes;
        logic             depth_nz;
        logic             stack_full;
        t_stack_ent       top;
    } t_ctx;

    // Verdict of the entry checks.
    typedef struct packed {
        t_err             err;
        logic             push;
        logic [IDX_W-1:0] total;
    } t_check;

endpackage

[hw/rtl/fdtp_entry_check.sv]
// ----------------------------------------------------------------------------
// fdtp_entry_check
// Root and entry checks: error code, push decision and entry count.
// ----------------------------------------------------------------------------
module fdtp_entry_check (
    input  fdtp_pkg::t_entry i_ent,
    input  fdtp_pkg::t_ctx   i_ctx,
    output fdtp_pkg::t_check o_chk
);
    import fdtp_pkg::*;

    logic [35:0]       w3_x12;
    logic [TB_W-1:0]   root_rest;
    logic [TB_W:0]     total_x12;
    logic [TB_W:0]     str_area;
    logic              name_bad;
    logic              bounds_bad;

    // Root: count times twelve against the table size.
    assign w3_x12    = (36'(i_ent.w3) << 3) + (36'(i_ent.w3) << 2);
    assign root_rest = i_ctx.table_bytes - w3_x12[TB_W-1:0];

    // Later entries: the string area follows the entry array.
    assign total_x12 = ((TB_W+1)'(i_ctx.total) << 3) + ((TB_W+1)'(i_ctx.total) << 2);
    assign str_area  = ((TB_W+1)'(i_ctx.table_bytes) > total_x12)
                     ? (TB_W+1)'(i_ctx.table_bytes) - total_x12 : '0;
    assign name_bad  = NAME_W'(str_area) <= i_ent.name;

    assign bounds_bad = (i_ent.w2 != WORD_W'(i_ctx.top.dir_idx))
                     || (i_ent.w3 <= WORD_W'(i_ctx.idx))
                     || (i_ent.w3 >  WORD_W'(i_ctx.total))
                     || (i_ent.w3 >  WORD_W'(i_ctx.top.end_idx));

    always_comb begin
        o_chk.err   = ERR_NONE;
        o_chk.push  = 1'b0;
        o_chk.total = i_ctx.total;
        if (i_ent.start) begin
            o_chk.total = '0;
            if (i_ctx.table_bytes < ENTRY_BYTES || i_ent.kind == 8'd0) begin
                o_chk.err = ERR_ROOT;
            end else if (i_ent.w3 == '0 || w3_x12 > 36'(i_ctx.table_bytes)) begin
                o_chk.err = ERR_COUNT;
            end else begin
                o_chk.total = i_ent.w3[IDX_W-1:0];
                o_chk.push  = 1'b1;
                if (root_rest == '0) begin
                    o_chk.err = ERR_NO_STR;
                end else if (i_ent.name >= NAME_W'(root_rest)) begin
                    o_chk.err = ERR_NAME;
                end
            end
        end else if (!i_ctx.depth_nz) begin
            o_chk.err = ERR_OUTSIDE;
        end else begin
            if (name_bad) begin
                o_chk.err = ERR_NAME;
            end else if (i_ent.kind != 8'd0) begin
                if (bounds_bad) begin
                    o_chk.err = ERR_DIR_BOUND;
                end else if (i_ctx.stack_full) begin
                    o_chk.err = ERR_OVERFLOW;
                end else begin
                    o_chk.push = 1'b1;
                end
            end
        end
    end

endmodule

[hw/rtl/fst_directory_table_parser_core.sv]
// ----------------------------------------------------------------------------
// fst_directory_table_parser_core
// Streaming parser for the entry table of a disc file system. One 12-byte
// table entry comes in per beat; the beat flagged in tuser is the root and
// restarts parsing. Every entry produces exactly one result beat with its
// index, its parent directory, a file mark and, for files, the file ordinal,
// the byte offset (word offset times four) and the size. Open directories
// live in a small synchronous stack memory, with the top entry mirrored in
// registers. An entry is accepted, then checked and its result registered
// once the stack walk has closed each directory that it ends, popping one
// level per cycle through the single read port. A result beat may also wait
// for the downstream side; the next entry is accepted while it waits. The
// first error reported after a root stays in every later result until the
// next root. The table size register may only be written while idle.
// ----------------------------------------------------------------------------
module fst_directory_table_parser_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration: total table size in bytes.
    input  logic                       i_cfg_we,
    input  logic [fdtp_pkg::TB_W-1:0]  i_cfg_wdata,
    // Entry stream.
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata from bit 0: kind_byte[7:0], name_ptr[31:8],
    // second_word[63:32], third_word[95:64].
    input  logic [95:0]                s_axis_tdata,
    // tuser: start_of_table.
    input  logic                       s_axis_tuser,
    // Result stream.
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // tdata from bit 0: entry_number[18:0], parent_number[37:19],
    // file_ordinal[56:38], file_byte_offset[90:57], file_bytes[122:91],
    // error_code[125:123], zero padding[127:126].
    output logic [127:0]               m_axis_tdata,
    // tuser: is_file.
    output logic                       m_axis_tuser,
    // tlast: last_entry.
    output logic                       m_axis_tlast
);
    import fdtp_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WORK = 2'b10
    } t_state;

    t_state            r_state, n_state;
    t_entry            r_ent;
    logic [IDX_W-1:0]  r_cur;
    logic [IDX_W-1:0]  r_total;
    logic [IDX_W-1:0]  r_files;
    logic [DW-1:0]     r_depth;
    t_err              r_sticky;
    logic [TB_W-1:0]   r_table_bytes;
    t_stack_ent        r_top;

    // Stack memory: entry 0 is the root, entry r_depth-1 mirrors r_top.
    t_stack_ent        r_stack [STACK_DEPTH];
    t_stack_ent        r_rd_data;
    logic [AW-1:0]     rd_addr;
    logic              stk_we;
    logic [AW-1:0]     stk_waddr;
    t_stack_ent        stk_wdata;

    logic              r_m_valid;
    logic [127:0]      r_m_data;
    logic              r_m_user;
    logic              r_m_last;

    logic              in_fire;
    logic              pop;
    logic              fin;
    logic [IDX_W-1:0]  next_idx;
    logic [DW-1:0]     depth_m2;
    logic [DW-1:0]     depth_m3;
    t_ctx              ctx;
    t_check            chk;
    t_err              n_sticky;
    logic              is_file;
    logic [IDX_W-1:0]  ordinal;
    logic [IDX_W-1:0]  parent;
    logic [33:0]       offset;
    logic [WORD_W-1:0] bytes;
    logic              last;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Index of the arriving entry; it saturates at the largest index.
    assign next_idx = s_axis_tuser ? '0
                    : (r_cur == IDX_MAX) ? IDX_MAX : r_cur + IDX_W'(1);

    // A directory whose end index is reached closes before the entry is checked.
    assign pop = (r_state == S_WORK) && !r_ent.start && (r_depth != '0)
              && (r_cur >= r_top.end_idx);
    assign fin = (r_state == S_WORK) && !pop && (!r_m_valid || m_axis_tready);

    assign ctx.idx         = r_cur;
    assign ctx.total       = r_total;
    assign ctx.table_bytes = r_table_bytes;
    assign ctx.depth_nz    = (r_depth != '0);
    assign ctx.stack_full  = (r_depth >= DW'(STACK_DEPTH));
    assign ctx.top         = r_top;

    fdtp_entry_check u_check (
        .i_ent (r_ent),
        .i_ctx (ctx),
        .o_chk (chk)
    );

    // In idle and during a pop, the read port fetches the entry just below the
    // top, so that a pop can take its new top from the registered read data.
    assign depth_m2 = r_depth - DW'(2);
    assign depth_m3 = r_depth - DW'(3);
    always_comb begin
        rd_addr = '0;
        if (r_state == S_IDLE && r_depth >= DW'(2)) begin
            rd_addr = depth_m2[AW-1:0];
        end else if (pop && r_depth >= DW'(3)) begin
            rd_addr = depth_m3[AW-1:0];
        end
    end

    assign stk_we            = fin && chk.push;
    assign stk_waddr         = r_ent.start ? '0 : r_depth[AW-1:0];
    assign stk_wdata.dir_idx = r_cur;
    assign stk_wdata.end_idx = r_ent.start ? chk.total : r_ent.w3[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_waddr] <= stk_wdata;
        end
        r_rd_data <= r_stack[rd_addr];
    end

    // Result fields.
    assign is_file = !r_ent.start && (r_ent.kind == 8'd0);
    assign ordinal = is_file ? r_files : '0;
    assign parent  = (!r_ent.start && r_depth != '0) ? r_top.dir_idx : '0;
    assign offset  = is_file ? {r_ent.w2, 2'b00} : '0;
    assign bytes   = is_file ? r_ent.w3 : '0;
    assign n_sticky = (r_ent.start || r_sticky == ERR_NONE) ? chk.err : r_sticky;
    assign last    = (chk.total != '0) && (r_cur == chk.total - IDX_W'(1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_WORK;
                end
            end
            S_WORK: begin
                if (fin) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cur         <= '0;
            r_total       <= '0;
            r_files       <= '0;
            r_depth       <= '0;
            r_sticky      <= ERR_NONE;
            r_table_bytes <= TB_RESET;
            r_m_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_table_bytes <= i_cfg_wdata;
            end
            if (in_fire) begin
                r_cur <= next_idx;
            end
            if (pop) begin
                r_depth <= r_depth - DW'(1);
            end
            if (fin) begin
                r_total  <= chk.total;
                r_sticky <= n_sticky;
                if (r_ent.start) begin
                    r_files <= '0;
                    r_depth <= chk.push ? DW'(1) : '0;
                end else begin
                    if (is_file && r_files != IDX_MAX) begin
                        r_files <= r_files + IDX_W'(1);
                    end
                    if (chk.push) begin
                        r_depth <= r_depth + DW'(1);
                    end
                end
            end
            if (fin) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ent.start <= s_axis_tuser;
            r_ent.kind  <= s_axis_tdata[7:0];
            r_ent.name  <= s_axis_tdata[31:8];
            r_ent.w2    <= s_axis_tdata[63:32];
            r_ent.w3    <= s_axis_tdata[95:64];
        end
        if (pop) begin
            r_top <= r_rd_data;
        end else if (stk_we) begin
            r_top <= stk_wdata;
        end
        if (fin) begin
            r_m_data <= {2'b00, n_sticky, bytes, offset, ordinal, parent, r_cur};
            r_m_user <= is_file;
            r_m_last <= last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tlast  = r_m_last;

    // The stack never grows past its memory.
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(STACK_DEPTH))
        else $error("directory stack depth exceeds its memory");

    // A rejected root leaves no directory open.
    a_root_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin && r_ent.start && (chk.err == ERR_ROOT || chk.err == ERR_COUNT))
        |=> (r_depth == '0) && (r_total == '0))
        else $error("rejected root left the stack open");

    // A reported error holds until the next root.
    a_sticky_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin && !r_ent.start && r_sticky != ERR_NONE)
        |=> r_sticky == $past(r_sticky))
        else $error("sticky error changed without a new root");

    // A pop always leaves one level fewer.
    a_pop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> r_depth == $past(r_depth) - DW'(1))
        else $error("stack pop did not lower the depth by one");

endmodule
